@@ rtl/assert_macros.svh @@
// Assertion helper macros for the request scheduler RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ssch_pkg.sv @@
// Shared types, constants and decode for the SSTF request scheduler.
// No dependencies.
`default_nettype none

package ssch_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int SECTOR_BITS = 48;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int TAG_BITS    = 8;
   localparam int COUNT_BITS  = 16;
   localparam int CMD_BITS    = 2;

   localparam logic [CMD_BITS-1:0] CMD_ADD      = CMD_BITS'(0);
   localparam logic [CMD_BITS-1:0] CMD_DISPATCH = CMD_BITS'(1);

   typedef enum logic [1:0] {
      OP_ADD,
      OP_DISPATCH,
      OP_REMOVE
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED      = 3'd0,
      ST_DISPATCHED = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_FULL       = 3'd3,
      ST_REMOVED    = 3'd4,
      ST_NOT_FOUND  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]    tag;
      logic [SECTOR_BITS-1:0] start;
      logic [COUNT_BITS-1:0]  count;
   } slot_type;

   typedef struct packed {
      op_type   op;
      slot_type slot;
   } item_type;

   typedef struct packed {
      status_type status;
      slot_type   slot;
   } result_type;

   function automatic op_type decode_cmd(input logic [CMD_BITS-1:0] cmd);
      op_type op;
      case (cmd)
         CMD_ADD:      op = OP_ADD;
         CMD_DISPATCH: op = OP_DISPATCH;
         default:      op = OP_REMOVE;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ssch_slot_ram.sv @@
// Slot table memory: one write port, one read port, registered read data.
// Depends on ssch_pkg.
`default_nettype none

module ssch_slot_ram (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ssch_pkg::IDX_BITS-1:0] wr_addr,
   input  wire ssch_pkg::slot_type       wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ssch_pkg::IDX_BITS-1:0] rd_addr,
   output ssch_pkg::slot_type            rd_data
);
   import ssch_pkg::*;

   slot_type mem_ff [TABLE_DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/ssch_engine.sv @@
// Scan engine: sweeps the slot memory, picks the slot for the command, commits.
// Depends on ssch_pkg and ssch_slot_ram.
`default_nettype none

module ssch_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire ssch_pkg::item_type   item,
   input  wire logic                 out_free,
   output logic                      idle,
   output logic                      done,
   output ssch_pkg::result_type      result
);
   import ssch_pkg::*;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);

   state_type state_ff, state_in;

   item_type                item_ff;
   logic [TABLE_DEPTH-1:0]  valid_ff;
   logic [SECTOR_BITS-1:0]  head_ff;
   logic [IDX_BITS-1:0]     scan_cnt_ff, scan_cnt_in;

   // stage 1: read data back from memory
   logic                    p1_vld_ff;
   logic                    p1_live_ff;
   logic [IDX_BITS-1:0]     p1_idx_ff;
   slot_type                rd_data;

   // stage 2: distance and tag match registered
   logic                    p2_vld_ff;
   logic                    p2_live_ff;
   logic                    p2_hit_ff;
   logic [IDX_BITS-1:0]     p2_idx_ff;
   logic [SECTOR_BITS-1:0]  p2_dist_ff;
   slot_type                p2_slot_ff;

   logic                    found_ff;
   logic [IDX_BITS-1:0]     best_idx_ff;
   logic [SECTOR_BITS-1:0]  best_dist_ff;
   slot_type                best_slot_ff;

   logic                    scan_issue;
   logic [SECTOR_BITS-1:0]  seek_dist;
   logic                    take;
   logic                    ram_wr_en;

   ssch_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (best_idx_ff),
      .wr_data (item_ff.slot),
      .rd_en   (scan_issue),
      .rd_addr (scan_cnt_ff),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_cnt_ff == LAST_IDX) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!p1_vld_ff && !p2_vld_ff) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      idle       = 1'b0;
      scan_issue = 1'b0;
      done       = 1'b0;
      case (state_ff)
         S_IDLE:   idle       = 1'b1;
         S_SCAN:   scan_issue = 1'b1;
         S_COMMIT: done       = out_free;
         default:  idle       = 1'b0;
      endcase
   end

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (start) begin
         scan_cnt_in = '0;
      end else if (scan_issue) begin
         scan_cnt_in = scan_cnt_ff + IDX_BITS'(1);
      end
   end

   always_comb begin
      if (rd_data.start >= head_ff) begin
         seek_dist = rd_data.start - head_ff;
      end else begin
         seek_dist = head_ff - rd_data.start;
      end
   end

   always_comb begin
      case (item_ff.op)
         OP_ADD:      take = !found_ff && !p2_live_ff;
         OP_DISPATCH: take = p2_live_ff && (!found_ff || (p2_dist_ff < best_dist_ff) ||
                             ((p2_dist_ff == best_dist_ff) &&
                              (p2_slot_ff.start > best_slot_ff.start)));
         default:     take = !found_ff && p2_live_ff && p2_hit_ff;
      endcase
   end

   assign ram_wr_en = done && found_ff && (item_ff.op == OP_ADD);

   always_comb begin
      result = '0;
      case (item_ff.op)
         OP_ADD: begin
            result.status = found_ff ? ST_ADDED : ST_FULL;
         end
         OP_DISPATCH: begin
            if (found_ff) begin
               result.status = ST_DISPATCHED;
               result.slot   = best_slot_ff;
            end else begin
               result.status = ST_EMPTY;
            end
         end
         default: begin
            result.status = found_ff ? ST_REMOVED : ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         scan_cnt_ff <= '0;
         valid_ff    <= '0;
         head_ff     <= '0;
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         p1_vld_ff   <= scan_issue;
         p2_vld_ff   <= p1_vld_ff;
         if (start) begin
            found_ff <= 1'b0;
         end else if (p2_vld_ff && take) begin
            found_ff <= 1'b1;
         end
         if (done && found_ff) begin
            valid_ff[best_idx_ff] <= (item_ff.op == OP_ADD);
         end
         if (done && found_ff && (item_ff.op == OP_DISPATCH)) begin
            head_ff <= best_slot_ff.start + SECTOR_BITS'(best_slot_ff.count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= item;
      end
      p1_live_ff <= valid_ff[scan_cnt_ff];
      p1_idx_ff  <= scan_cnt_ff;
      p2_live_ff <= p1_live_ff;
      p2_idx_ff  <= p1_idx_ff;
      p2_hit_ff  <= (rd_data.tag == item_ff.slot.tag);
      p2_dist_ff <= seek_dist;
      p2_slot_ff <= rd_data;
      if (p2_vld_ff && take) begin
         best_idx_ff  <= p2_idx_ff;
         best_dist_ff <= p2_dist_ff;
         best_slot_ff <= p2_slot_ff;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sstf_request_scheduler.sv @@
// Channel  | Dir | Handshake             | Payload
// req_     | in  | req_valid / req_ready | req_cmd, req_tag, req_start_sector, req_sector_count
// rsp_     | out | rsp_valid / rsp_ready | rsp_status, rsp_out_tag, rsp_out_sector, rsp_out_count
//
// Every command sweeps all TABLE_DEPTH slots through the slot memory read port, one a cycle;
// the result goes to the output register at commit, and the next beat can be taken in the cycle after.
// Reset clears the slot valid bits and the head position at once; no clearing pass.
// A result waits in the output register; a new beat is taken while it waits,
// but the commit of that beat holds until the register is free.
// Depends on ssch_pkg, ssch_engine, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sstf_request_scheduler (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [ssch_pkg::CMD_BITS-1:0]       req_cmd,
   input  wire logic [ssch_pkg::TAG_BITS-1:0]       req_tag,
   input  wire logic [ssch_pkg::SECTOR_BITS-1:0]    req_start_sector,
   input  wire logic [ssch_pkg::COUNT_BITS-1:0]     req_sector_count,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [2:0]                               rsp_status,
   output logic [ssch_pkg::TAG_BITS-1:0]            rsp_out_tag,
   output logic [ssch_pkg::SECTOR_BITS-1:0]         rsp_out_sector,
   output logic [ssch_pkg::COUNT_BITS-1:0]          rsp_out_count
);
   import ssch_pkg::*;

   item_type   item;
   logic       start;
   logic       eng_idle;
   logic       eng_done;
   logic       out_free;
   result_type eng_result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   assign item.op         = decode_cmd(req_cmd);
   assign item.slot.tag   = req_tag;
   assign item.slot.start = req_start_sector;
   assign item.slot.count = req_sector_count;

   assign req_ready = eng_idle;
   assign start     = req_valid && eng_idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   ssch_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (item),
      .out_free (out_free),
      .idle     (eng_idle),
      .done     (eng_done),
      .result   (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_out_tag    = rsp_data_ff.slot.tag;
   assign rsp_out_sector = rsp_data_ff.slot.start;
   assign rsp_out_count  = rsp_data_ff.slot.count;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready,
      "scheduler still ready after accepting a beat")
   `ASSERT_IMPLY(a_result_with_idle, clock, reset, $rose(rsp_valid), req_ready,
      "result raised while engine still busy")
   `ASSERT_IMPLY(a_zero_fields, clock, reset, rsp_valid && (rsp_status != ST_DISPATCHED),
      (rsp_out_tag == '0) && (rsp_out_sector == '0) && (rsp_out_count == '0),
      "non-dispatch result carries request fields")
   `ASSERT_ALWAYS(a_status_range, clock, reset, !rsp_valid || (rsp_status <= ST_NOT_FOUND),
      "result status out of range")

endmodule

`default_nettype wire
